@@ rtl/mtkd_pkg.sv @@
// Shared types, codes and the two fixed key layouts of the multi-tap keypad decoder.
// No dependencies; imported by mtkd_step and multi_tap_keypad_decoder_core.
`default_nettype none

package mtkd_pkg;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_PRESS  = 2'd1,
    CMD_ENTER  = 2'd2,
    CMD_ESCAPE = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_SHIFT_KEY  = 3'd0;
  localparam logic [2:0] REG_SWITCH_KEY = 3'd1;
  localparam logic [2:0] REG_ESCAPE_KEY = 3'd2;
  localparam logic [2:0] REG_NONE_KEY   = 3'd3;
  localparam logic [2:0] REG_COMMIT     = 3'd4;

  localparam logic [7:0] MARK_SHIFT     = 8'h01;
  localparam logic [7:0] MARK_SWITCH    = 8'h02;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_A         = 8'h61;
  localparam logic [7:0] CHAR_Z         = 8'h7A;
  localparam logic [3:0] COUNT_TOP      = 4'd15;
  localparam logic [2:0] COL_MAX        = 3'd4;

  typedef struct packed {
    logic [7:0] shift_key_code;
    logic [7:0] switch_key_code;
    logic [7:0] escape_key_code;
    logic [7:0] none_key_code;
    logic [3:0] commit_polls;
  } cfg_t;

  typedef struct packed {
    logic       layout_sel;
    logic       single_latched;
    logic       shift_flag;
    logic [7:0] pending_code;
    logic [3:0] poll_count;
  } state_t;

  typedef struct packed {
    logic       numeric_layout;
    logic       shift_on;
    logic [7:0] key_code;
  } result_t;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] first;
  } key_syms_t;

  // Index: layout, table row, column. Unused columns read as an empty key.
  function automatic key_syms_t key_lookup(input logic layout, input logic [1:0] trow,
                                           input logic [2:0] col);
    key_syms_t k;
    k = '0;
    case ({layout, trow, col})
      6'b0_00_000: k = '{"w", "q"};
      6'b0_00_001: k = '{"r", "e"};
      6'b0_00_010: k = '{"y", "t"};
      6'b0_00_011: k = '{"i", "u"};
      6'b0_00_100: k = '{"p", "o"};
      6'b0_01_000: k = '{"s", "a"};
      6'b0_01_001: k = '{"f", "d"};
      6'b0_01_010: k = '{"h", "g"};
      6'b0_01_011: k = '{"k", "j"};
      6'b0_01_100: k = '{CODE_QUOTE, "l"};
      6'b0_10_000: k = '{"x", "z"};
      6'b0_10_001: k = '{"v", "c"};
      6'b0_10_010: k = '{"n", "b"};
      6'b0_10_011: k = '{",", "m"};
      6'b0_10_100: k = '{8'h00, CODE_BACKSPACE};
      6'b0_11_000: k = '{8'h00, MARK_SHIFT};
      6'b0_11_001: k = '{8'h00, " "};
      6'b0_11_010: k = '{8'h00, " "};
      6'b0_11_011: k = '{8'h00, MARK_SWITCH};
      6'b1_00_000: k = '{8'h00, "1"};
      6'b1_00_001: k = '{8'h00, "2"};
      6'b1_00_010: k = '{8'h00, "3"};
      6'b1_00_011: k = '{8'h00, "+"};
      6'b1_00_100: k = '{8'h00, "*"};
      6'b1_01_000: k = '{8'h00, "4"};
      6'b1_01_001: k = '{8'h00, "5"};
      6'b1_01_010: k = '{8'h00, "6"};
      6'b1_01_011: k = '{8'h00, "-"};
      6'b1_01_100: k = '{8'h00, "/"};
      6'b1_10_000: k = '{8'h00, "7"};
      6'b1_10_001: k = '{8'h00, "8"};
      6'b1_10_010: k = '{8'h00, "9"};
      6'b1_10_011: k = '{8'h00, "="};
      6'b1_10_100: k = '{8'h00, CODE_BACKSPACE};
      6'b1_11_000: k = '{8'h00, "."};
      6'b1_11_001: k = '{8'h00, "0"};
      6'b1_11_010: k = '{")", "("};
      6'b1_11_011: k = '{8'h00, MARK_SWITCH};
      default:     k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mtkd_step.sv @@
// Next-state and result logic for one decoder event (press, poll, enter, escape).
// Depends on mtkd_pkg for the layout table, command codes and state types.
`default_nettype none

module mtkd_step import mtkd_pkg::*; (
  input  var cfg_t       cfg,
  input  var state_t     st,
  input  var cmd_t       cmd,
  input  wire [1:0]      scan_row,
  input  wire [2:0]      scan_col,
  output var state_t     st_next,
  output var result_t    res
);

  key_syms_t  k;
  logic [7:0] resolved;
  logic [3:0] count_inc;

  always_comb begin
    k = key_lookup(st.layout_sel, ~scan_row, scan_col);
    if (k.first == MARK_SHIFT) begin
      resolved = cfg.shift_key_code;
    end else if (k.first == MARK_SWITCH) begin
      resolved = cfg.switch_key_code;
    end else begin
      resolved = k.first;
    end
    count_inc = (st.poll_count < COUNT_TOP) ? st.poll_count + 4'd1 : st.poll_count;
  end

  always_comb begin
    st_next = st;
    res.key_code = cfg.none_key_code;
    unique case (cmd)
      CMD_POLL: begin
        if (st.single_latched) begin
          st_next.single_latched = 1'b0;
          st_next.poll_count = '0;
          st_next.pending_code = '0;
          if (st.pending_code == cfg.shift_key_code) begin
            st_next.shift_flag = ~st.shift_flag;
          end else if (st.pending_code == cfg.switch_key_code) begin
            st_next.layout_sel = ~st.layout_sel;
          end else begin
            res.key_code = st.pending_code;
          end
        end else begin
          st_next.poll_count = count_inc;
          if (count_inc > cfg.commit_polls) begin
            st_next.poll_count = '0;
            st_next.pending_code = '0;
            res.key_code = st.pending_code;
            if (st.shift_flag && st.pending_code >= CHAR_A && st.pending_code <= CHAR_Z) begin
              res.key_code = st.pending_code - CASE_OFFSET;
              st_next.shift_flag = 1'b0;
            end
          end
        end
      end
      CMD_PRESS: begin
        if (scan_col <= COL_MAX && k.first != 8'h00) begin
          if (k.second == 8'h00) begin
            st_next.single_latched = 1'b1;
            st_next.pending_code = resolved;
          end else begin
            st_next.single_latched = 1'b0;
            st_next.poll_count = '0;
            st_next.pending_code = (st.pending_code == k.first) ? k.second : k.first;
          end
        end
      end
      CMD_ENTER: begin
        st_next.single_latched = 1'b1;
        st_next.pending_code = CODE_NEWLINE;
      end
      CMD_ESCAPE: begin
        st_next.single_latched = 1'b1;
        st_next.pending_code = cfg.escape_key_code;
      end
      default: ;
    endcase
    res.shift_on = st_next.shift_flag;
    res.numeric_layout = st_next.layout_sel;
  end

endmodule

`default_nettype wire

@@ rtl/multi_tap_keypad_decoder_core.sv @@
// Multi-tap keypad decoder: input register, event logic, result register.
// Depends on mtkd_pkg and mtkd_step.
//
// Each transfer on the slave side is an event: a poll tick, a matrix press, or the enter or
// escape button. Only polls yield a result transfer, carrying the emitted character (or the
// "none" code) with the shift and layout state after the poll. One event is taken per cycle
// unless a stalled poll holds the input register; the decode step runs combinationally from
// input register to result register, so a poll's result is registered when the poll leaves
// the input register. The result register lets the next events keep flowing while a result
// waits; only a poll that would overwrite an untaken result stalls. Configuration writes take
// effect at the next clock edge and are meant to happen while no event is in flight.
`default_nettype none

module multi_tap_keypad_decoder_core import mtkd_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,  // [1:0] scan_row, [4:2] scan_col, rest zero
  input  wire [1:0]  s_axis_tuser,  // [1:0] command
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata, // [7:0] key_code, [8] shift_on, [9] numeric_layout
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  cfg_t       cfg;
  state_t     st;
  state_t     st_next;
  result_t    res;
  logic       in_valid;
  cmd_t       in_cmd;
  logic [1:0] in_row;
  logic [2:0] in_col;
  logic       adv;

  always_comb begin
    adv = in_valid && (in_cmd != CMD_POLL || !m_axis_tvalid || m_axis_tready);
    s_axis_tready = !in_valid || adv;
  end

  mtkd_step u_step (
    .cfg      (cfg),
    .st       (st),
    .cmd      (in_cmd),
    .scan_row (in_row),
    .scan_col (in_col),
    .st_next  (st_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_key_code  <= 8'd1;
      cfg.switch_key_code <= 8'd2;
      cfg.escape_key_code <= 8'd27;
      cfg.none_key_code   <= 8'd0;
      cfg.commit_polls    <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_KEY:  cfg.shift_key_code  <= cfg_data;
        REG_SWITCH_KEY: cfg.switch_key_code <= cfg_data;
        REG_ESCAPE_KEY: cfg.escape_key_code <= cfg_data;
        REG_NONE_KEY:   cfg.none_key_code   <= cfg_data;
        REG_COMMIT:     cfg.commit_polls    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_row <= s_axis_tdata[1:0];
      in_col <= s_axis_tdata[4:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && in_cmd == CMD_POLL) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_cmd == CMD_POLL) begin
      m_axis_tdata <= {6'd0, res};
    end
  end

  a_poll_gives_result: assert property (@(posedge clk) disable iff (rst)
    (adv && in_cmd == CMD_POLL) |=> m_axis_tvalid)
    else $error("poll transfer left no result");

  a_enter_latches: assert property (@(posedge clk) disable iff (rst)
    (adv && in_cmd == CMD_ENTER) |=> (st.single_latched && st.pending_code == CODE_NEWLINE))
    else $error("enter did not latch newline");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("empty input stage refused a transfer");

  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(adv && in_cmd == CMD_POLL))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ dv/multi_tap_keypad_decoder_core_tb.sv @@
// Self-checking testbench for multi_tap_keypad_decoder_core: a directed table, then random
// key sequences under several register settings, with random stalls on both stream sides.
// Depends on mtkd_pkg and the core RTL.
`timescale 1ns / 100ps

module multi_tap_keypad_decoder_core_tb;
  import mtkd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_EVENTS = 1200;
  localparam int PHASES        = 6;

  typedef struct packed {
    logic       regs_row;
    cfg_t       regs;
    cmd_t       cmd;
    logic [1:0] row;
    logic [2:0] col;
    logic       pinned;
    result_t    pin;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // tags travelling with the event being offered
  logic        evt_pinned = 1'b0;
  result_t     evt_pin = '0;

  bit          calm = 1'b0;
  int          sink_hold = 0;
  int          cycles = 0;
  int          mismatches = 0;
  int          events_taken = 0;
  int          results_seen = 0;
  int          events_sent = 0;

  // decoder model state and registers
  logic       m_layout, m_latched, m_shift;
  logic [7:0] m_pending;
  logic [3:0] m_count;
  logic [7:0] r_shift, r_switch, r_escape, r_none;
  logic [3:0] r_commit;

  result_t    expected_chars [$];
  stim_row_t  directed_rows [29];

  multi_tap_keypad_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Symbols of a key; col must be 0..4.
  function automatic key_syms_t keypad_syms(input logic numeric, input logic [1:0] trow,
                                            input logic [2:0] col);
    logic [79:0] pairs;
    logic [39:0] singles;
    key_syms_t   k;
    k = '0;
    if (!numeric) begin
      case (trow)
        2'd0:    pairs = "qwertyuiop";
        2'd1:    pairs = "asdfghjkl\"";
        2'd2:    pairs = {"zxcvbnm,", CODE_BACKSPACE, 8'h00};
        default: pairs = {MARK_SHIFT, 8'h00, " ", 8'h00, " ", 8'h00, MARK_SWITCH, 24'h0};
      endcase
      k.first  = pairs[79 - 16 * col -: 8];
      k.second = pairs[71 - 16 * col -: 8];
    end else begin
      case (trow)
        2'd0:    singles = "123+*";
        2'd1:    singles = "456-/";
        2'd2:    singles = {"789=", CODE_BACKSPACE};
        default: singles = {".0(", MARK_SWITCH, 8'h00};
      endcase
      k.first = singles[39 - 8 * col -: 8];
      if (trow == 2'd3 && col == 3'd2) k.second = ")";
    end
    return k;
  endfunction

  task automatic decode_event(input cmd_t cmd, input logic [1:0] row, input logic [2:0] col,
                              output bit has_char, output result_t r);
    key_syms_t  k;
    logic [7:0] v;
    has_char = 1'b0;
    r = '0;
    v = '0;
    case (cmd)
      CMD_POLL: begin
        has_char = 1'b1;
        if (m_latched) begin
          m_latched = 1'b0;
          m_count = '0;
          if (m_pending == r_shift) begin
            m_shift = ~m_shift;
            v = r_none;
          end else if (m_pending == r_switch) begin
            m_layout = ~m_layout;
            v = r_none;
          end else begin
            v = m_pending;
          end
          m_pending = '0;
        end else begin
          if (m_count != COUNT_TOP) m_count = m_count + 4'd1;
          if (m_count > r_commit) begin
            m_count = '0;
            v = m_pending;
            m_pending = '0;
            if (m_shift && v >= CHAR_A && v <= CHAR_Z) begin
              v = v - CASE_OFFSET;
              m_shift = 1'b0;
            end
          end else begin
            v = r_none;
          end
        end
        r.key_code = v;
        r.shift_on = m_shift;
        r.numeric_layout = m_layout;
      end
      CMD_PRESS: begin
        if (col <= COL_MAX) begin
          k = keypad_syms(m_layout, 2'd3 - row, col);
          if (k.first != 8'h00) begin
            if (k.second == 8'h00) begin
              m_latched = 1'b1;
              m_pending = (k.first == MARK_SHIFT) ? r_shift :
                          (k.first == MARK_SWITCH) ? r_switch : k.first;
            end else begin
              m_latched = 1'b0;
              m_count = '0;
              m_pending = (m_pending == k.first) ? k.second : k.first;
            end
          end
        end
      end
      CMD_ENTER: begin
        m_latched = 1'b1;
        m_pending = CODE_NEWLINE;
      end
      default: begin
        m_latched = 1'b1;
        m_pending = r_escape;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    result_t got, want;
    bit      has_char;
    if (rst) begin
      m_layout = 1'b0; m_latched = 1'b0; m_shift = 1'b0; m_pending = '0; m_count = '0;
      r_shift = MARK_SHIFT; r_switch = MARK_SWITCH; r_escape = 8'd27; r_none = 8'd0;
      r_commit = 4'd10;
      expected_chars.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[9:0]);
        results_seen++;
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing pending, key_code", int'(got.key_code), 0);
        end else begin
          want = expected_chars.pop_front();
          if (got.key_code != want.key_code)
            report_mismatch("key_code", int'(got.key_code), int'(want.key_code));
          if (got.shift_on != want.shift_on)
            report_mismatch("shift_on", int'(got.shift_on), int'(want.shift_on));
          if (got.numeric_layout != want.numeric_layout)
            report_mismatch("numeric_layout", int'(got.numeric_layout),
                            int'(want.numeric_layout));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SHIFT_KEY:  r_shift = cfg_data;
          REG_SWITCH_KEY: r_switch = cfg_data;
          REG_ESCAPE_KEY: r_escape = cfg_data;
          REG_NONE_KEY:   r_none = cfg_data;
          REG_COMMIT:     r_commit = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        events_taken++;
        decode_event(cmd_t'(s_axis_tuser), s_axis_tdata[1:0], s_axis_tdata[4:2], has_char, want);
        if (has_char) expected_chars.push_back(evt_pinned ? evt_pin : want);
      end
    end
  end

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 11) == 0) sink_hold <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("multi_tap_keypad_decoder_core verification failed");
      $finish;
    end
  end

  task automatic send_event(input cmd_t cmd, input logic [1:0] row, input logic [2:0] col,
                            input logic pinned, input result_t pin);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, col, row};
    evt_pinned    <= pinned;
    evt_pin       <= pin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    events_sent++;
  endtask

  task automatic send_plain(input cmd_t cmd, input logic [1:0] row, input logic [2:0] col);
    send_event(cmd, row, col, 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHIFT_KEY;
    cfg_data  <= v.shift_key_code;
    @(posedge clk);
    cfg_index <= REG_SWITCH_KEY;
    cfg_data  <= v.switch_key_code;
    @(posedge clk);
    cfg_index <= REG_ESCAPE_KEY;
    cfg_data  <= v.escape_key_code;
    @(posedge clk);
    cfg_index <= REG_NONE_KEY;
    cfg_data  <= v.none_key_code;
    @(posedge clk);
    cfg_index <= REG_COMMIT;
    cfg_data  <= {4'h0, v.commit_polls};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic stim_row_t evt_row(input cmd_t c, input logic [1:0] r,
                                        input logic [2:0] k);
    stim_row_t s;
    s = '0;
    s.cmd = c;
    s.row = r;
    s.col = k;
    return s;
  endfunction

  function automatic stim_row_t poll_row(input logic [7:0] key, input logic shift,
                                         input logic numeric);
    stim_row_t s;
    s = '0;
    s.cmd = CMD_POLL;
    s.pinned = 1'b1;
    s.pin.key_code = key;
    s.pin.shift_on = shift;
    s.pin.numeric_layout = numeric;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_t c);
    stim_row_t s;
    s = '0;
    s.regs_row = 1'b1;
    s.regs = c;
    return s;
  endfunction

  // one well-formed key sequence with random content, or a little noise
  task automatic random_sequence();
    logic [1:0] row;
    logic [2:0] col;
    int         n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (m_layout) begin
          row = 2'd0;
          col = 3'd2;
        end else begin
          row = 2'($urandom_range(1, 3));
          col = 3'($urandom_range(0, 3));
        end
        n = $urandom_range(1, 3);
        repeat (n) send_plain(CMD_PRESS, row, col);
        if ($urandom_range(0, 3) == 0) send_plain(CMD_PRESS, 2'($urandom_range(0, 3)),
                                                  3'($urandom_range(0, 4)));
        n = r_commit + 1 + $urandom_range(0, 2);
        repeat (n) send_plain(CMD_POLL, 2'd0, 3'd0);
      end
      4, 5: begin
        send_plain(CMD_PRESS, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 4)));
        repeat ($urandom_range(1, 2)) send_plain(CMD_POLL, 2'd0, 3'd0);
      end
      6: begin
        send_plain($urandom_range(0, 1) ? CMD_ENTER : CMD_ESCAPE, 2'($urandom_range(0, 3)),
                   3'($urandom_range(0, 7)));
        send_plain(CMD_POLL, 2'd0, 3'd0);
      end
      7: begin
        send_plain(CMD_PRESS, 2'd0, $urandom_range(0, 1) ? 3'd0 : 3'd3);
        send_plain(CMD_POLL, 2'd0, 3'd0);
      end
      default: begin
        repeat ($urandom_range(1, 4))
          send_plain(cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     3'($urandom_range(0, 7)));
      end
    endcase
  endtask

  initial begin
    cfg_t phase_cfg;
    int   target;
    directed_rows = '{
      poll_row(8'h00, 1'b0, 1'b0),
      evt_row(CMD_PRESS, 2'd0, 3'd0),
      poll_row(8'h00, 1'b1, 1'b0),
      cfg_row('{MARK_SHIFT, MARK_SWITCH, 8'd27, 8'd0, 4'd0}),
      evt_row(CMD_PRESS, 2'd3, 3'd0),
      evt_row(CMD_PRESS, 2'd3, 3'd0),
      poll_row("W", 1'b0, 1'b0),
      poll_row(8'h00, 1'b0, 1'b0),
      evt_row(CMD_PRESS, 2'd3, 3'd7),
      evt_row(CMD_PRESS, 2'd0, 3'd4),
      poll_row(8'h00, 1'b0, 1'b0),
      evt_row(CMD_ENTER, 2'd0, 3'd0),
      poll_row(CODE_NEWLINE, 1'b0, 1'b0),
      evt_row(CMD_ESCAPE, 2'd3, 3'd7),
      poll_row(8'd27, 1'b0, 1'b0),
      evt_row(CMD_PRESS, 2'd0, 3'd3),
      poll_row(8'h00, 1'b0, 1'b1),
      evt_row(CMD_PRESS, 2'd0, 3'd2),
      evt_row(CMD_PRESS, 2'd0, 3'd2),
      poll_row(")", 1'b0, 1'b1),
      evt_row(CMD_PRESS, 2'd1, 3'd4),
      poll_row(CODE_BACKSPACE, 1'b0, 1'b1),
      cfg_row('{CODE_BACKSPACE, CODE_NEWLINE, 8'hFF, 8'hFF, 4'd15}),
      evt_row(CMD_PRESS, 2'd1, 3'd4),
      poll_row(8'hFF, 1'b1, 1'b1),
      evt_row(CMD_ENTER, 2'd0, 3'd0),
      poll_row(8'hFF, 1'b1, 1'b0),
      evt_row(CMD_ESCAPE, 2'd0, 3'd0),
      poll_row(8'hFF, 1'b1, 1'b0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].regs_row)
        program_regs(directed_rows[i].regs);
      else
        send_event(directed_rows[i].cmd, directed_rows[i].row, directed_rows[i].col,
                   directed_rows[i].pinned, directed_rows[i].pin);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 4'd0};
        1: phase_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd15};
        default: begin
          phase_cfg.shift_key_code  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                   : MARK_SHIFT;
          phase_cfg.switch_key_code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                   : MARK_SWITCH;
          phase_cfg.escape_key_code = 8'($urandom_range(0, 255));
          phase_cfg.none_key_code   = 8'($urandom_range(0, 255));
          phase_cfg.commit_polls    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                                   : 4'($urandom_range(0, 3));
        end
      endcase
      program_regs(phase_cfg);
      if (p == PHASES - 1) calm = 1'b1;
      target = events_sent + RANDOM_EVENTS / PHASES;
      while (events_sent < target) begin
        random_sequence();
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d events (directed table, %0d register settings incl. all-zero and all-max)",
             events_taken, PHASES + 3);
    $display("Compared %0d polled characters; %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("multi_tap_keypad_decoder_core verification clean");
    else
      $display("multi_tap_keypad_decoder_core verification failed");
    $finish;
  end

endmodule
